// ----- sv/omm_pkg.sv -----
// omm_pkg: shared types, mode codes, constants and helpers for the rocking motor
// mode controller. Used by omm_step and oscillating_motor_mode_controller.
// No dependencies.
package omm_pkg;

  // startup timeout and middle settle time, in ticks
  localparam logic [15:0] STARTUP_TICKS       = 16'd350;
  localparam logic [7:0]  MIDDLE_SETTLE_TICKS = 8'd150;

  localparam logic [15:0] FREQ_RESET   = 16'd50;
  localparam logic [7:0]  PERCENT_FULL = 8'd100;

  // x / 6 for 16-bit x: (x * ceil(2^18 / 6)) >> 18 is exact over the whole range
  localparam logic [15:0] DIV6_RECIP = 16'd43691;
  localparam int unsigned DIV6_SHIFT = 18;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROCK_FREQ    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_FREQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_PERCENT = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // external binary mode codes
  localparam logic [2:0] MODE_CODE_OFF       = 3'd0;
  localparam logic [2:0] MODE_CODE_ON        = 3'd1;
  localparam logic [2:0] MODE_CODE_SEEK      = 3'd2;
  localparam logic [2:0] MODE_CODE_SEEKWAIT  = 3'd3;
  localparam logic [2:0] MODE_CODE_ROCKSTART = 3'd4;
  localparam logic [2:0] MODE_CODE_ROCK      = 3'd5;

  typedef enum logic [5:0] {
    MODE_OFF       = 6'b000001,
    MODE_ON        = 6'b000010,
    MODE_SEEK      = 6'b000100,
    MODE_SEEKWAIT  = 6'b001000,
    MODE_ROCKSTART = 6'b010000,
    MODE_ROCK      = 6'b100000
  } mode_e;

  typedef struct packed {
    logic       cmd;
    logic [2:0] new_mode;
    logic       left_event;
    logic       left_active;
    logic       right_event;
    logic       right_active;
    logic       middle_event;
    logic       middle_active;
    logic       on_live_page;
    logic [7:0] percent;
  } omm_in_t;

  typedef struct packed {
    logic        drive_enable;
    logic        drive_dir;
    logic [15:0] drive_freq;
    logic        pulse_gate;
    logic [2:0]  mode_now;
  } omm_out_t;

  typedef struct packed {
    logic [15:0] rock_freq;
    logic [15:0] fixed_freq;
    logic [6:0]  stop_percent;
  } omm_cfg_t;

  function automatic logic [2:0] mode_to_code(mode_e m);
    logic [2:0] c;
    case (m)
      MODE_OFF:       c = MODE_CODE_OFF;
      MODE_ON:        c = MODE_CODE_ON;
      MODE_SEEK:      c = MODE_CODE_SEEK;
      MODE_SEEKWAIT:  c = MODE_CODE_SEEKWAIT;
      MODE_ROCKSTART: c = MODE_CODE_ROCKSTART;
      MODE_ROCK:      c = MODE_CODE_ROCK;
      default:        c = MODE_CODE_OFF;
    endcase
    return c;
  endfunction

  function automatic mode_e code_to_mode(logic [2:0] c);
    mode_e m;
    case (c)
      MODE_CODE_OFF:       m = MODE_OFF;
      MODE_CODE_ON:        m = MODE_ON;
      MODE_CODE_SEEK:      m = MODE_SEEK;
      MODE_CODE_SEEKWAIT:  m = MODE_SEEKWAIT;
      MODE_CODE_ROCKSTART: m = MODE_ROCKSTART;
      MODE_CODE_ROCK:      m = MODE_ROCK;
      default:             m = MODE_OFF;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] div6(logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(DIV6_RECIP);
    return 16'(p >> DIV6_SHIFT);
  endfunction

endpackage

// ----- sv/oscillating_motor_mode_controller.sv -----
// oscillating_motor_mode_controller: top level with input register, result register
// and configuration registers around omm_step.
// Depends on omm_pkg and omm_step.

// Takes one transaction per cycle while in_stall_o is low and returns one result
// per transaction; each is held in the input register, then passes through the mode
// step logic into the result register. The input register holds while a stalled
// result waits, so a transaction is then taken only if the input register is empty.
// A tick (cmd 0) runs the startup timeout, steps the mode and applies pending limit
// events; a set-mode transaction (cmd 1) only loads the mode and latches switch
// events. Configuration writes are for the user to make only while idle; the block
// itself does not enforce it. They go straight to the step logic.
module oscillating_motor_mode_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  omm_pkg::omm_in_t                  in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output omm_pkg::omm_out_t                 out_item_o,
  input  logic                              cfg_we_i,
  input  logic [omm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [omm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  logic              in_valid_q;
  omm_pkg::omm_in_t  in_item_q;
  logic              out_valid_q;
  omm_pkg::omm_out_t out_item_q;
  omm_pkg::omm_cfg_t cfg_q;
  omm_pkg::omm_out_t res;
  logic              out_free;
  logic              step;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        omm_pkg::CFG_ROCK_FREQ:    cfg_q.rock_freq    <= cfg_wdata_i;
        omm_pkg::CFG_FIXED_FREQ:   cfg_q.fixed_freq   <= cfg_wdata_i;
        omm_pkg::CFG_STOP_PERCENT: cfg_q.stop_percent <= cfg_wdata_i[6:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  omm_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- sv/omm_step.sv -----
// omm_step: controller state (mode, startup timer, settle counter, drive registers,
// pending switch events) and the per-transaction update logic.
// Depends on omm_pkg.
module omm_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  omm_pkg::omm_in_t  item_i,
  input  omm_pkg::omm_cfg_t cfg_i,
  output omm_pkg::omm_out_t res_o
);

  omm_pkg::mode_e mode_q, mode_d;
  logic        armed_q, armed_d;
  logic [15:0] count_q, count_d;
  logic        seen_q, seen_d;
  logic [7:0]  wait_q, wait_d;
  logic        enable_q, enable_d;
  logic        dir_q, dir_d;
  logic [15:0] freq_q, freq_d;
  logic        gate_q, gate_d;
  logic [2:0]  pend_q, pend_d;   // bit0 left, bit1 right, bit2 middle

  always_comb begin
    mode_d   = mode_q;
    armed_d  = armed_q;
    count_d  = count_q;
    seen_d   = seen_q;
    wait_d   = wait_q;
    enable_d = enable_q;
    dir_d    = dir_q;
    freq_d   = freq_q;
    gate_d   = gate_q;
    pend_d   = pend_q | {item_i.middle_event, item_i.right_event, item_i.left_event};

    if (item_i.cmd) begin
      // codes above rock are ignored
      if (item_i.new_mode <= omm_pkg::MODE_CODE_ROCK) begin
        mode_d = omm_pkg::code_to_mode(item_i.new_mode);
      end
    end else begin
      if (armed_q) begin
        count_d = count_q + 16'd1;
        if (count_q >= omm_pkg::STARTUP_TICKS) begin
          armed_d = 1'b0;
          mode_d  = omm_pkg::MODE_SEEK;
        end
      end

      case (mode_d)
        omm_pkg::MODE_OFF: begin
          gate_d   = 1'b0;
          enable_d = 1'b0;
        end
        omm_pkg::MODE_ON: begin
          gate_d   = 1'b0;
          enable_d = 1'b1;
        end
        omm_pkg::MODE_SEEK: begin
          gate_d   = 1'b1;
          enable_d = 1'b1;
          freq_d   = omm_pkg::div6(cfg_i.fixed_freq);
          seen_d   = 1'b0;
          mode_d   = omm_pkg::MODE_SEEKWAIT;
        end
        omm_pkg::MODE_SEEKWAIT: begin
          if (!seen_q && pend_d[2]) begin
            pend_d[2] = 1'b0;
            if (item_i.middle_active) begin
              seen_d = 1'b1;
              wait_d = omm_pkg::MIDDLE_SETTLE_TICKS;
            end
          end else if (seen_q) begin
            // wraps from zero when seekwait is forced with middle already seen
            wait_d = wait_q - 8'd1;
            if (wait_d == 8'd0) begin
              mode_d = omm_pkg::MODE_ON;
            end
          end
        end
        omm_pkg::MODE_ROCKSTART: begin
          gate_d   = 1'b1;
          enable_d = 1'b1;
          freq_d   = cfg_i.rock_freq;
          mode_d   = omm_pkg::MODE_ROCK;
        end
        omm_pkg::MODE_ROCK: begin
          if (item_i.on_live_page && (item_i.percent >= {1'b0, cfg_i.stop_percent})
              && (item_i.percent < omm_pkg::PERCENT_FULL)) begin
            mode_d = omm_pkg::MODE_SEEK;
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase

      // left limit wins, right stays pending meanwhile
      if (pend_d[0]) begin
        pend_d[0] = 1'b0;
        if (item_i.left_active) begin
          dir_d = 1'b0;
        end
      end else if (pend_d[1]) begin
        pend_d[1] = 1'b0;
        if (item_i.right_active) begin
          dir_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= omm_pkg::MODE_OFF;
      armed_q  <= 1'b1;
      count_q  <= '0;
      seen_q   <= 1'b0;
      wait_q   <= omm_pkg::MIDDLE_SETTLE_TICKS;
      enable_q <= 1'b0;
      dir_q    <= 1'b0;
      freq_q   <= omm_pkg::FREQ_RESET;
      gate_q   <= 1'b0;
      pend_q   <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      armed_q  <= armed_d;
      count_q  <= count_d;
      seen_q   <= seen_d;
      wait_q   <= wait_d;
      enable_q <= enable_d;
      dir_q    <= dir_d;
      freq_q   <= freq_d;
      gate_q   <= gate_d;
      pend_q   <= pend_d;
    end
  end

  // result shows the state after this transaction
  always_comb begin
    res_o.drive_enable = enable_d;
    res_o.drive_dir    = dir_d;
    res_o.drive_freq   = freq_d;
    res_o.pulse_gate   = gate_d;
    res_o.mode_now     = omm_pkg::mode_to_code(mode_d);
  end

  // startup timeout always lands in seekwait via seek
  a_startup_to_seekwait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(armed_q) |-> (mode_q == omm_pkg::MODE_SEEKWAIT))
    else $error("startup timeout did not enter seekwait");

  a_startup_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |=> !armed_q)
    else $error("startup timeout rearmed");

  a_middle_seen_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(seen_q) |-> (mode_q == omm_pkg::MODE_SEEKWAIT
                       && wait_q == omm_pkg::MIDDLE_SETTLE_TICKS))
    else $error("middle seen outside seekwait or without settle reload");

  a_gate_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gate_q |-> enable_q)
    else $error("pulse gate running with driver disabled");

endmodule

// ----- dv/tb_oscillating_motor_mode_controller.sv -----
// Self-checking testbench for oscillating_motor_mode_controller: a local model predicts
// every result from each accepted transaction and a checker compares them as they arrive.
// Depends on omm_pkg and the controller RTL.
module tb_oscillating_motor_mode_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_ITEMS    = 80;
  localparam logic [15:0] SEEK_DIVIDER   = 16'd6;
  // mode codes that a set-mode transaction must leave without effect
  localparam logic [2:0]  MODE_CODE_BAD6 = 3'd6;
  localparam logic [2:0]  MODE_CODE_BAD7 = 3'd7;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  omm_pkg::omm_in_t               in_item_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  omm_pkg::omm_out_t              out_item_o;
  logic                           cfg_we_i;
  logic [omm_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [omm_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  oscillating_motor_mode_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // register copies
  logic [15:0] set_rock_freq;
  logic [15:0] set_fixed_freq;
  logic [6:0]  set_stop_pct;

  // controller model state
  logic [2:0]  ctl_mode;
  logic        boot_armed;
  logic [15:0] boot_ticks;
  logic        mid_found;
  logic [7:0]  settle_left;
  logic        drv_en;
  logic        drv_dir;
  logic [15:0] drv_freq;
  logic        drv_gate;
  logic        pend_left;
  logic        pend_right;
  logic        pend_mid;

  omm_pkg::omm_out_t expected_drive_q[$];
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  logic        hold_req;
  logic        hold_ack;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_controller_model();
    set_rock_freq  = '0;
    set_fixed_freq = '0;
    set_stop_pct   = '0;
    ctl_mode       = omm_pkg::MODE_CODE_OFF;
    boot_armed     = 1'b1;
    boot_ticks     = '0;
    mid_found      = 1'b0;
    settle_left    = omm_pkg::MIDDLE_SETTLE_TICKS;
    drv_en         = 1'b0;
    drv_dir        = 1'b0;
    drv_freq       = omm_pkg::FREQ_RESET;
    drv_gate       = 1'b0;
    pend_left      = 1'b0;
    pend_right     = 1'b0;
    pend_mid       = 1'b0;
  endfunction

  function automatic omm_pkg::omm_out_t advance_controller(input omm_pkg::omm_in_t it);
    omm_pkg::omm_out_t r;
    logic [15:0]       prev_ticks;
    if (it.left_event) pend_left = 1'b1;
    if (it.right_event) pend_right = 1'b1;
    if (it.middle_event) pend_mid = 1'b1;
    if (it.cmd) begin
      if (it.new_mode <= omm_pkg::MODE_CODE_ROCK) ctl_mode = it.new_mode;
    end else begin
      if (boot_armed) begin
        prev_ticks = boot_ticks;
        boot_ticks = boot_ticks + 16'd1;
        if (prev_ticks >= omm_pkg::STARTUP_TICKS) begin
          boot_armed = 1'b0;
          ctl_mode   = omm_pkg::MODE_CODE_SEEK;
        end
      end
      case (ctl_mode)
        omm_pkg::MODE_CODE_OFF: begin
          drv_gate = 1'b0;
          drv_en   = 1'b0;
        end
        omm_pkg::MODE_CODE_ON: begin
          drv_gate = 1'b0;
          drv_en   = 1'b1;
        end
        omm_pkg::MODE_CODE_SEEK: begin
          drv_gate  = 1'b1;
          drv_en    = 1'b1;
          drv_freq  = set_fixed_freq / SEEK_DIVIDER;
          mid_found = 1'b0;
          ctl_mode  = omm_pkg::MODE_CODE_SEEKWAIT;
        end
        omm_pkg::MODE_CODE_SEEKWAIT: begin
          if (!mid_found && pend_mid) begin
            pend_mid = 1'b0;
            if (it.middle_active) begin
              mid_found   = 1'b1;
              settle_left = omm_pkg::MIDDLE_SETTLE_TICKS;
            end
          end else if (mid_found) begin
            // 8-bit countdown, wraps when entered with nothing left
            settle_left = settle_left - 8'd1;
            if (settle_left == 8'd0) ctl_mode = omm_pkg::MODE_CODE_ON;
          end
        end
        omm_pkg::MODE_CODE_ROCKSTART: begin
          drv_gate = 1'b1;
          drv_en   = 1'b1;
          drv_freq = set_rock_freq;
          ctl_mode = omm_pkg::MODE_CODE_ROCK;
        end
        omm_pkg::MODE_CODE_ROCK: begin
          if (it.on_live_page && it.percent >= {1'b0, set_stop_pct} &&
              it.percent < omm_pkg::PERCENT_FULL)
            ctl_mode = omm_pkg::MODE_CODE_SEEK;
        end
        default: ;
      endcase
      // left wins; right stays pending
      if (pend_left) begin
        pend_left = 1'b0;
        if (it.left_active) drv_dir = 1'b0;
      end else if (pend_right) begin
        pend_right = 1'b0;
        if (it.right_active) drv_dir = 1'b1;
      end
    end
    r.drive_enable = drv_en;
    r.drive_dir    = drv_dir;
    r.drive_freq   = drv_freq;
    r.pulse_gate   = drv_gate;
    r.mode_now     = ctl_mode;
    return r;
  endfunction

  // receiver side: random stalls plus an occasional long hold-off
  initial begin : receiver_stall
    int unsigned hold_cnt;
    hold_cnt    = 0;
    hold_ack    = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    omm_pkg::omm_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_drive_q.size() == 0) begin
        $error("result transaction arrived with nothing expected: %h", out_item_o);
        fail_count++;
      end else begin
        want = expected_drive_q.pop_front();
        if (out_item_o.drive_enable !== want.drive_enable) begin
          $error("drive_enable: expected %0d, got %0d", want.drive_enable,
                 out_item_o.drive_enable);
          fail_count++;
        end
        if (out_item_o.drive_dir !== want.drive_dir) begin
          $error("drive_dir: expected %0d, got %0d", want.drive_dir, out_item_o.drive_dir);
          fail_count++;
        end
        if (out_item_o.drive_freq !== want.drive_freq) begin
          $error("drive_freq: expected %0d, got %0d", want.drive_freq,
                 out_item_o.drive_freq);
          fail_count++;
        end
        if (out_item_o.pulse_gate !== want.pulse_gate) begin
          $error("pulse_gate: expected %0d, got %0d", want.pulse_gate,
                 out_item_o.pulse_gate);
          fail_count++;
        end
        if (out_item_o.mode_now !== want.mode_now) begin
          $error("mode_now: expected %0d, got %0d", want.mode_now, out_item_o.mode_now);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_item(input omm_pkg::omm_in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    expected_drive_q.push_back(advance_controller(it));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [omm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      omm_pkg::CFG_ROCK_FREQ:    set_rock_freq = val;
      omm_pkg::CFG_FIXED_FREQ:   set_fixed_freq = val;
      omm_pkg::CFG_STOP_PERCENT: set_stop_pct = val[6:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [15:0] rock, input logic [15:0] fixed,
                             input logic [6:0] stop);
    wait_idle();
    write_cfg(omm_pkg::CFG_ROCK_FREQ, rock);
    write_cfg(omm_pkg::CFG_FIXED_FREQ, fixed);
    write_cfg(omm_pkg::CFG_STOP_PERCENT, {9'd0, stop});
  endtask

  function automatic void set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endfunction

  // sw = {left_event, left_active, right_event, right_active, middle_event, middle_active}
  function automatic omm_pkg::omm_in_t mk_item(input logic cmd, input logic [2:0] nm,
                                               input logic [5:0] sw, input logic live,
                                               input logic [7:0] pct);
    return {cmd, nm, sw, live, pct};
  endfunction

  function automatic logic [7:0] pick_percent();
    int p;
    case ($urandom_range(2))
      0:       p = $urandom_range(255);
      1:       p = int'(set_stop_pct) + int'($urandom_range(6)) - 3;
      default: p = 97 + int'($urandom_range(5));
    endcase
    if (p < 0) p = 0;
    if (p > 255) p = 255;
    return 8'(p);
  endfunction

  function automatic omm_pkg::omm_in_t rand_tick(input int unsigned ev_pct);
    omm_pkg::omm_in_t t;
    t.cmd           = 1'b0;
    t.new_mode      = 3'($urandom);
    t.left_event    = ($urandom_range(99) < ev_pct);
    t.left_active   = 1'($urandom);
    t.right_event   = ($urandom_range(99) < ev_pct);
    t.right_active  = 1'($urandom);
    t.middle_event  = ($urandom_range(99) < ev_pct);
    t.middle_active = 1'($urandom);
    t.on_live_page  = 1'($urandom);
    t.percent       = pick_percent();
    return t;
  endfunction

  function automatic omm_pkg::omm_in_t set_item(input logic [2:0] m);
    omm_pkg::omm_in_t t;
    t          = rand_tick(20);
    t.cmd      = 1'b1;
    t.new_mode = m;
    return t;
  endfunction

  function automatic omm_pkg::omm_in_t noise_item();
    logic [31:0] raw;
    raw = $urandom;
    return omm_pkg::omm_in_t'(raw[$bits(omm_pkg::omm_in_t)-1:0]);
  endfunction

  // ticks until the seek wait is left by settling, or until the loop guard runs out
  task automatic settle_ticks();
    int unsigned guard;
    guard = 0;
    while (ctl_mode == omm_pkg::MODE_CODE_SEEKWAIT && guard < 600) begin
      send_item(rand_tick(20));
      guard++;
    end
  endtask

  task automatic rock_run(input int unsigned n);
    send_item(set_item(omm_pkg::MODE_CODE_ROCKSTART));
    repeat (n) send_item(rand_tick(25));
  endtask

  task automatic test_mode_walk();
    load_config(16'hFFFF, 16'hFFFF, 7'd0);
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
    // every field but cmd at its top value: left wins, right stays pending
    send_item(mk_item(1'b0, MODE_CODE_BAD7, 6'b111111, 1'b1, 8'd255));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000100, 1'b0, 8'd0));
    send_item(mk_item(1'b1, omm_pkg::MODE_CODE_ON, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b1, MODE_CODE_BAD6, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b1, MODE_CODE_BAD7, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b1, omm_pkg::MODE_CODE_SEEK, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b1, omm_pkg::MODE_CODE_ROCKSTART, 6'b100000, 1'b0, 8'd0));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
    // percent at or above full never stops the rocking
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b001100, 1'b1, 8'd255));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b110000, 1'b1, 8'd100));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd50));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b1, 8'd99));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b1, omm_pkg::MODE_CODE_ROCK, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b1, 8'd0));
    send_item(mk_item(1'b1, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
  endtask

  task automatic test_middle_settle();
    // middle event latched by a set-mode transaction
    send_item(mk_item(1'b1, omm_pkg::MODE_CODE_SEEK, 6'b000010, 1'b0, 8'd0));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
    // consumed with the level inactive: not seen
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000011, 1'b0, 8'd0));
    settle_ticks();
    // middle event outside the seek wait stays pending
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000011, 1'b0, 8'd0));
    // re-entering the wait with the countdown spent makes it wrap
    send_item(mk_item(1'b1, omm_pkg::MODE_CODE_SEEKWAIT, 6'b000000, 1'b0, 8'd0));
    repeat (4) send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b1, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
    send_item(mk_item(1'b0, omm_pkg::MODE_CODE_OFF, 6'b000000, 1'b0, 8'd0));
  endtask

  task automatic config_case(input logic [15:0] rock, input logic [15:0] fixed,
                             input logic [6:0] stop);
    load_config(rock, fixed, stop);
    rock_run(10);
    send_item(set_item(omm_pkg::MODE_CODE_SEEK));
    send_item(rand_tick(10));
  endtask

  task automatic test_config_extremes();
    config_case(16'hFFFF, 16'hFFFF, 7'd100);
    config_case(16'h0000, 16'h0000, 7'd0);
    config_case(16'h5555, 16'd5, 7'd127);
    config_case(16'hAAAA, 16'd6, 7'd101);
    config_case(16'h0001, 16'd11, 7'd99);
    config_case(16'h8000, 16'd12, 7'd1);
  endtask

  // receiver holds off while the sender keeps offering, so the input backs up
  task automatic test_pressure();
    wait_idle();
    set_idling(0, 0);
    hold_req = ~hold_req;
    rock_run(20);
    repeat (20) send_item(noise_item());
  endtask

  task automatic test_random();
    int unsigned send_pcts[4];
    int unsigned recv_pcts[4];
    int unsigned target;
    int unsigned pick;
    send_pcts = '{0, 53, 0, 19};
    recv_pcts = '{0, 0, 53, 19};
    for (int ph = 0; ph < 4; ph++) begin
      set_idling(send_pcts[ph], recv_pcts[ph]);
      load_config(16'($urandom), 16'($urandom), 7'($urandom_range(127)));
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          send_item(set_item(omm_pkg::MODE_CODE_SEEK));
          send_item(rand_tick(20));
          settle_ticks();
        end else if (pick < 55) begin
          rock_run($urandom_range(3, 25));
        end else if (pick < 75) begin
          repeat ($urandom_range(5, 15)) send_item(rand_tick(60));
        end else begin
          repeat ($urandom_range(1, 8)) send_item(noise_item());
        end
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    hold_req    = 1'b0;
    fail_count  = 0;
    items_sent  = 0;
    set_idling(0, 0);
    reset_controller_model();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_mode_walk();
    test_middle_settle();
    test_config_extremes();
    test_pressure();
    test_random();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
